/* hw/rtl/isw_pkg.sv */
// ----------------------------------------------------------------------------
// isw_pkg: shared types and constants of the static window detector
// Sizes of the sample ring, arithmetic widths, item and result records.
// ----------------------------------------------------------------------------
package isw_pkg;

    localparam int BUF_DEPTH = 256;
    localparam int IDX_W     = $clog2(BUF_DEPTH);
    localparam int CNT_W     = IDX_W + 1;
    localparam int STAMP_W   = 48;
    localparam int ACC_W     = 16;
    localparam int WIN_W     = 34;
    localparam int THR_W     = 24;
    localparam int STD_W     = 24;
    localparam int MEAN_W    = 24;
    localparam int S1_W      = ACC_W + CNT_W;
    localparam int SQ_W      = 2 * ACC_W;
    localparam int S2_W      = SQ_W + CNT_W - 2;
    localparam int P1_W      = S2_W + CNT_W;
    localparam int D_W       = 2 * S1_W;
    localparam int M_W       = 2 * IDX_W;
    localparam int DQ_W      = D_W + 16;
    localparam int ITER_W    = $clog2(DQ_W + 1);
    localparam int VAL_W     = 52;
    localparam int ROOT_W    = VAL_W / 2;
    localparam int SREM_W    = ROOT_W + 3;
    localparam int MEAN_DIV_W = S1_W + 8;

    localparam logic OP_SAMPLE = 1'b0;
    localparam logic OP_CLEAR  = 1'b1;

    // Byte addresses of the configuration registers.
    localparam logic [3:0] ADDR_WINDOW    = 4'h0;
    localparam logic [3:0] ADDR_THRESHOLD = 4'h8;

    typedef struct packed {
        logic                      is_clear;
        logic [STAMP_W-1:0]        stamp;
        logic signed [ACC_W-1:0]   accel_z;
        logic signed [ACC_W-1:0]   accel_y;
        logic signed [ACC_W-1:0]   accel_x;
    } item_t;

    typedef struct packed {
        logic                       coeff_valid;
        logic [STD_W-1:0]           std_dev_q8;
        logic                       is_static;
        logic [CNT_W-1:0]           window_count;
        logic signed [MEAN_W-1:0]   mean_x_q8;
        logic signed [MEAN_W-1:0]   mean_y_q8;
        logic signed [MEAN_W-1:0]   mean_z_q8;
    } result_t;

    typedef struct packed {
        logic                  start;
        logic [DQ_W-1:0]       dividend;
        logic [M_W-1:0]        divisor;
        logic [ITER_W-1:0]     iters;
    } div_req_t;

    typedef struct packed {
        logic [DQ_W-1:0]  quotient;
        logic [M_W-1:0]   remainder;
        logic             done;
    } div_rsp_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_STORE,
        ST_EVICT_RD,
        ST_EVICT_CHK,
        ST_WALK_RD,
        ST_WALK_ACC,
        ST_VAR_MUL,
        ST_VAR_ADD,
        ST_VDIV_GO,
        ST_VDIV_WAIT,
        ST_SQRT_GO,
        ST_SQRT_WAIT,
        ST_MEAN_GO,
        ST_MEAN_WAIT,
        ST_FINISH
    } back_state_t;

endpackage

/* hw/rtl/isw_front.sv */
// ----------------------------------------------------------------------------
// isw_front: input acceptance and classification
// Decodes each incoming word into an item and holds up to two in a queue.
// ----------------------------------------------------------------------------
module isw_front (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  logic [95:0]          s_tdata,
    input  logic [0:0]           s_tuser,
    output logic                 item_valid,
    output isw_pkg::item_t       item,
    input  logic                 item_take
);

    isw_pkg::item_t q_reg [2];
    logic       wr_ptr_reg, wr_ptr_next;
    logic       rd_ptr_reg, rd_ptr_next;
    logic [1:0] count_reg, count_next;
    logic       push, pop;
    isw_pkg::item_t in_item;

    assign s_tready   = (count_reg != 2'd2);
    assign push       = s_tvalid && s_tready;
    assign item_valid = (count_reg != 2'd0);
    assign pop        = item_valid && item_take;
    assign item       = q_reg[rd_ptr_reg];

    always_comb begin
        in_item.is_clear = (s_tuser[0] == isw_pkg::OP_CLEAR);
        in_item.stamp    = s_tdata[47:0];
        in_item.accel_x  = s_tdata[63:48];
        in_item.accel_y  = s_tdata[79:64];
        in_item.accel_z  = s_tdata[95:80];
        wr_ptr_next = push ? ~wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = pop ? ~rd_ptr_reg : rd_ptr_reg;
        count_next  = count_reg + {1'b0, push} - {1'b0, pop};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            q_reg[wr_ptr_reg] <= in_item;
        end
    end

endmodule

/* hw/rtl/isw_div.sv */
// ----------------------------------------------------------------------------
// isw_div: restoring divider
// Produces one quotient bit per cycle for a programmable number of steps.
// ----------------------------------------------------------------------------
module isw_div (
    input  logic                aclk,
    input  logic                aresetn,
    input  isw_pkg::div_req_t   req,
    output isw_pkg::div_rsp_t   rsp
);

    logic [isw_pkg::DQ_W-1:0]   dq_reg, dq_next;
    logic [isw_pkg::M_W-1:0]    rem_reg, rem_next;
    logic [isw_pkg::M_W-1:0]    dvs_reg, dvs_next;
    logic [isw_pkg::ITER_W-1:0] cnt_reg, cnt_next;
    logic                       busy_reg, busy_next;
    logic                       done_reg, done_next;
    logic [isw_pkg::M_W:0]      rem_sh;
    logic                       fits;

    assign rsp.quotient  = dq_reg;
    assign rsp.remainder = rem_reg;
    assign rsp.done      = done_reg;

    always_comb begin
        rem_sh    = {rem_reg, dq_reg[isw_pkg::DQ_W-1]};
        fits      = (rem_sh >= {1'b0, dvs_reg});
        dq_next   = dq_reg;
        rem_next  = rem_reg;
        dvs_next  = dvs_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (req.start) begin
            dq_next   = req.dividend;
            rem_next  = '0;
            dvs_next  = req.divisor;
            cnt_next  = req.iters;
            busy_next = 1'b1;
        end else if (busy_reg) begin
            dq_next  = {dq_reg[isw_pkg::DQ_W-2:0], fits};
            rem_next = fits ? isw_pkg::M_W'(rem_sh - {1'b0, dvs_reg})
                            : rem_sh[isw_pkg::M_W-1:0];
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == isw_pkg::ITER_W'(1)) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
        dq_reg  <= dq_next;
        rem_reg <= rem_next;
        dvs_reg <= dvs_next;
        cnt_reg <= cnt_next;
    end

endmodule

/* hw/rtl/isw_sqrt.sv */
// ----------------------------------------------------------------------------
// isw_sqrt: digit-by-digit integer square root
// Retires one root bit per cycle, floor of the square root of the radicand.
// ----------------------------------------------------------------------------
module isw_sqrt (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         start,
    input  logic [isw_pkg::VAL_W-1:0]    radicand,
    output logic [isw_pkg::ROOT_W-1:0]   root,
    output logic                         done
);

    localparam int CNT_SW = $clog2(isw_pkg::ROOT_W + 1);

    logic [isw_pkg::VAL_W-1:0]  rad_reg, rad_next;
    logic [isw_pkg::SREM_W-1:0] rem_reg, rem_next;
    logic [isw_pkg::ROOT_W-1:0] root_reg, root_next;
    logic [CNT_SW-1:0]          cnt_reg, cnt_next;
    logic                       busy_reg, busy_next;
    logic                       done_reg, done_next;
    logic [isw_pkg::SREM_W-1:0] rem_sh, trial;

    assign root = root_reg;
    assign done = done_reg;

    always_comb begin
        rem_sh    = {rem_reg[isw_pkg::SREM_W-3:0], rad_reg[isw_pkg::VAL_W-1 -: 2]};
        trial     = {1'b0, root_reg, 2'b01};
        rad_next  = rad_reg;
        rem_next  = rem_reg;
        root_next = root_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (start) begin
            rad_next  = radicand;
            rem_next  = '0;
            root_next = '0;
            cnt_next  = CNT_SW'(isw_pkg::ROOT_W);
            busy_next = 1'b1;
        end else if (busy_reg) begin
            rad_next = {rad_reg[isw_pkg::VAL_W-3:0], 2'b00};
            if (rem_sh >= trial) begin
                rem_next  = rem_sh - trial;
                root_next = {root_reg[isw_pkg::ROOT_W-2:0], 1'b1};
            end else begin
                rem_next  = rem_sh;
                root_next = {root_reg[isw_pkg::ROOT_W-2:0], 1'b0};
            end
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == CNT_SW'(1)) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
        rad_reg  <= rad_next;
        rem_reg  <= rem_next;
        root_reg <= root_next;
        cnt_reg  <= cnt_next;
    end

endmodule

/* hw/rtl/isw_back.sv */
// ----------------------------------------------------------------------------
// isw_back: sample ring, window walk and statistics sequencer
// Stores samples or clears the ring, evicts stale ones, sums the window and derives the result.
// ----------------------------------------------------------------------------
module isw_back (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          item_valid,
    input  isw_pkg::item_t                item,
    output logic                          item_take,
    input  logic [isw_pkg::WIN_W-1:0]     window_ns,
    input  logic [isw_pkg::THR_W-1:0]     threshold,
    output logic                          out_valid,
    output isw_pkg::result_t              out_result,
    input  logic                          out_ready
);

    localparam int SW = isw_pkg::STAMP_W;

    logic [SW-1:0]     stamp_mem [isw_pkg::BUF_DEPTH];
    logic [3*isw_pkg::ACC_W-1:0] accel_mem [isw_pkg::BUF_DEPTH];
    logic [SW-1:0]     stamp_q;
    logic [3*isw_pkg::ACC_W-1:0] accel_q;
    logic              rd_en, wr_en;
    logic [isw_pkg::IDX_W-1:0] rd_addr, wr_addr;

    isw_pkg::back_state_t state_reg, state_next;
    logic [isw_pkg::IDX_W-1:0] head_reg, head_next;
    logic [isw_pkg::CNT_W-1:0] fill_reg, fill_next;
    isw_pkg::item_t            item_reg, item_next;
    logic [isw_pkg::CNT_W-1:0] k_reg, k_next;
    logic [isw_pkg::CNT_W-1:0] n_reg, n_next;
    logic signed [isw_pkg::S1_W-1:0] s1_reg [3];
    logic signed [isw_pkg::S1_W-1:0] s1_next [3];
    logic [isw_pkg::S2_W-1:0]  s2_reg [3];
    logic [isw_pkg::S2_W-1:0]  s2_next [3];
    logic [isw_pkg::D_W-1:0]   d_reg, d_next;
    logic [isw_pkg::P1_W-1:0]  p1_reg, p1_next;
    logic [isw_pkg::D_W-1:0]   p2_reg, p2_next;
    logic [isw_pkg::M_W-1:0]   m_reg, m_next;
    logic [1:0]                axis_reg, axis_next;
    logic [SW-1:0]             limit_reg, limit_next;
    logic                      span_reg, span_next;
    logic                      valid_reg, valid_next;
    logic [isw_pkg::ROOT_W-1:0] std_reg, std_next;
    logic signed [isw_pkg::MEAN_W-1:0] mean_reg [3];
    logic signed [isw_pkg::MEAN_W-1:0] mean_next [3];
    logic                      out_valid_reg, out_valid_next;
    isw_pkg::result_t          out_reg, out_next;

    isw_pkg::div_req_t div_req;
    isw_pkg::div_rsp_t div_rsp;
    logic              sqrt_start;
    logic [isw_pkg::ROOT_W-1:0] sqrt_root;
    logic              sqrt_done;

    logic              full;
    logic [isw_pkg::IDX_W-1:0] head_st;
    logic [isw_pkg::CNT_W-1:0] fill_st;
    logic [isw_pkg::WIN_W:0]   age2;
    logic [SW-1:0]             age_t;
    logic                      in_win;
    logic signed [isw_pkg::ACC_W-1:0] v [3];
    logic signed [isw_pkg::SQ_W-1:0]  vsq [3];
    logic signed [isw_pkg::S1_W-1:0]  s1_sel;
    logic signed [2*isw_pkg::S1_W-1:0] s1_sq;
    logic [isw_pkg::S2_W-1:0]  s2_sel;
    logic [2*isw_pkg::CNT_W-1:0] nn;
    logic [isw_pkg::S1_W-1:0]  s1_abs;
    logic [isw_pkg::MEAN_DIV_W-1:0] q_mean;
    logic [isw_pkg::MEAN_DIV_W-1:0] q_adj;

    isw_div u_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .req     (div_req),
        .rsp     (div_rsp)
    );

    isw_sqrt u_sqrt (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (sqrt_start),
        .radicand (div_rsp.quotient[isw_pkg::VAL_W-1:0]),
        .root     (sqrt_root),
        .done     (sqrt_done)
    );

    assign out_valid  = out_valid_reg;
    assign out_result = out_reg;

    always_comb begin
        full    = (fill_reg == isw_pkg::CNT_W'(isw_pkg::BUF_DEPTH));
        head_st = full ? head_reg + 1'b1 : head_reg;
        fill_st = full ? fill_reg - 1'b1 : fill_reg;
        age2    = {window_ns, 1'b0};
        age_t   = item_reg.stamp - stamp_q;
        in_win  = (stamp_q <= item_reg.stamp) &&
                  (age_t < SW'(window_ns));
        v[0]    = accel_q[15:0];
        v[1]    = accel_q[31:16];
        v[2]    = accel_q[47:32];
        for (int a = 0; a < 3; a++) begin
            vsq[a] = v[a] * v[a];
        end
        s1_sel = s1_reg[axis_reg];
        s2_sel = s2_reg[axis_reg];
        s1_sq  = s1_sel * s1_sel;
        nn     = n_reg * (n_reg - 1'b1);
        s1_abs = s1_sel[isw_pkg::S1_W-1] ? isw_pkg::S1_W'(-s1_sel)
                                         : isw_pkg::S1_W'(s1_sel);
        q_mean = div_rsp.quotient[isw_pkg::MEAN_DIV_W-1:0];
        q_adj  = q_mean + {{(isw_pkg::MEAN_DIV_W-1){1'b0}}, (div_rsp.remainder != '0)};

        state_next     = state_reg;
        head_next      = head_reg;
        fill_next      = fill_reg;
        item_next      = item_reg;
        k_next         = k_reg;
        n_next         = n_reg;
        s1_next        = s1_reg;
        s2_next        = s2_reg;
        d_next         = d_reg;
        p1_next        = p1_reg;
        p2_next        = p2_reg;
        m_next         = m_reg;
        axis_next      = axis_reg;
        limit_next     = limit_reg;
        span_next      = span_reg;
        valid_next     = valid_reg;
        std_next       = std_reg;
        mean_next      = mean_reg;
        out_valid_next = out_valid_reg && !out_ready;
        out_next       = out_reg;
        item_take      = 1'b0;
        rd_en          = 1'b0;
        rd_addr        = head_reg;
        wr_en          = 1'b0;
        wr_addr        = head_st + fill_st[isw_pkg::IDX_W-1:0];
        div_req        = '0;
        sqrt_start     = 1'b0;

        case (state_reg)
            isw_pkg::ST_IDLE: begin
                if (item_valid) begin
                    item_take  = 1'b1;
                    item_next  = item;
                    k_next     = '0;
                    n_next     = '0;
                    d_next     = '0;
                    axis_next  = '0;
                    span_next  = 1'b0;
                    valid_next = 1'b0;
                    std_next   = '0;
                    for (int a = 0; a < 3; a++) begin
                        s1_next[a]   = '0;
                        s2_next[a]   = '0;
                        mean_next[a] = '0;
                    end
                    if (item.is_clear) begin
                        head_next  = '0;
                        fill_next  = '0;
                        state_next = isw_pkg::ST_FINISH;
                    end else begin
                        state_next = isw_pkg::ST_STORE;
                    end
                end
            end
            isw_pkg::ST_STORE: begin
                wr_en     = 1'b1;
                head_next = head_st;
                fill_next = fill_st + 1'b1;
                if ({{(SW-isw_pkg::WIN_W-1){1'b0}}, age2} <= item_reg.stamp) begin
                    limit_next = item_reg.stamp - SW'(age2);
                    state_next = isw_pkg::ST_EVICT_RD;
                end else begin
                    state_next = isw_pkg::ST_WALK_RD;
                end
            end
            isw_pkg::ST_EVICT_RD: begin
                rd_en      = 1'b1;
                rd_addr    = head_reg;
                state_next = isw_pkg::ST_EVICT_CHK;
            end
            isw_pkg::ST_EVICT_CHK: begin
                if (fill_reg != '0 && stamp_q < limit_reg) begin
                    head_next  = head_reg + 1'b1;
                    fill_next  = fill_reg - 1'b1;
                    state_next = isw_pkg::ST_EVICT_RD;
                end else begin
                    state_next = isw_pkg::ST_WALK_RD;
                end
            end
            isw_pkg::ST_WALK_RD: begin
                rd_en      = 1'b1;
                rd_addr    = head_reg + k_reg[isw_pkg::IDX_W-1:0];
                state_next = isw_pkg::ST_WALK_ACC;
            end
            isw_pkg::ST_WALK_ACC: begin
                // The first entry of the walk is the oldest one: it sets the span test.
                if (k_reg == '0) begin
                    span_next = (stamp_q <= item_reg.stamp) &&
                                (age_t >= SW'(window_ns));
                end
                if (in_win) begin
                    n_next = n_reg + 1'b1;
                    for (int a = 0; a < 3; a++) begin
                        s1_next[a] = s1_reg[a] + isw_pkg::S1_W'(v[a]);
                        s2_next[a] = s2_reg[a] +
                                     isw_pkg::S2_W'($unsigned(vsq[a]));
                    end
                end
                k_next = k_reg + 1'b1;
                if (k_reg + 1'b1 == fill_reg) begin
                    state_next = isw_pkg::ST_VAR_MUL;
                    axis_next  = '0;
                end else begin
                    state_next = isw_pkg::ST_WALK_RD;
                end
            end
            isw_pkg::ST_VAR_MUL: begin
                // Decide validity once the window is summed, then form n*S2 and S1^2.
                if (axis_reg == '0) begin
                    valid_next = (fill_reg >= isw_pkg::CNT_W'(2)) && span_reg &&
                                 (n_reg >= isw_pkg::CNT_W'(2));
                    m_next     = nn[isw_pkg::M_W-1:0];
                end
                if (axis_reg == '0 && !((fill_reg >= isw_pkg::CNT_W'(2)) && span_reg &&
                                        (n_reg >= isw_pkg::CNT_W'(2)))) begin
                    state_next = (n_reg != '0) ? isw_pkg::ST_MEAN_GO : isw_pkg::ST_FINISH;
                end else begin
                    p1_next    = isw_pkg::P1_W'(n_reg) * isw_pkg::P1_W'(s2_sel);
                    p2_next    = isw_pkg::D_W'($unsigned(s1_sq));
                    state_next = isw_pkg::ST_VAR_ADD;
                end
            end
            isw_pkg::ST_VAR_ADD: begin
                d_next = d_reg + isw_pkg::D_W'(p1_reg) - p2_reg;
                if (axis_reg == 2'd2) begin
                    axis_next  = '0;
                    state_next = isw_pkg::ST_VDIV_GO;
                end else begin
                    axis_next  = axis_reg + 1'b1;
                    state_next = isw_pkg::ST_VAR_MUL;
                end
            end
            isw_pkg::ST_VDIV_GO: begin
                div_req.start    = 1'b1;
                div_req.dividend = {d_reg, 16'b0};
                div_req.divisor  = m_reg;
                div_req.iters    = isw_pkg::ITER_W'(isw_pkg::DQ_W);
                state_next       = isw_pkg::ST_VDIV_WAIT;
            end
            isw_pkg::ST_VDIV_WAIT: begin
                if (div_rsp.done) begin
                    state_next = isw_pkg::ST_SQRT_GO;
                end
            end
            isw_pkg::ST_SQRT_GO: begin
                sqrt_start = 1'b1;
                state_next = isw_pkg::ST_SQRT_WAIT;
            end
            isw_pkg::ST_SQRT_WAIT: begin
                if (sqrt_done) begin
                    std_next   = sqrt_root;
                    axis_next  = '0;
                    state_next = isw_pkg::ST_MEAN_GO;
                end
            end
            isw_pkg::ST_MEAN_GO: begin
                div_req.start    = 1'b1;
                div_req.dividend = {s1_abs, 8'b0,
                                    {(isw_pkg::DQ_W-isw_pkg::MEAN_DIV_W){1'b0}}};
                div_req.divisor  = isw_pkg::M_W'(n_reg);
                div_req.iters    = isw_pkg::ITER_W'(isw_pkg::MEAN_DIV_W);
                state_next       = isw_pkg::ST_MEAN_WAIT;
            end
            isw_pkg::ST_MEAN_WAIT: begin
                if (div_rsp.done) begin
                    // A negative sum rounds toward minus infinity.
                    mean_next[axis_reg] = s1_sel[isw_pkg::S1_W-1]
                        ? isw_pkg::MEAN_W'(-q_adj) : isw_pkg::MEAN_W'(q_mean);
                    if (axis_reg == 2'd2) begin
                        state_next = isw_pkg::ST_FINISH;
                    end else begin
                        axis_next  = axis_reg + 1'b1;
                        state_next = isw_pkg::ST_MEAN_GO;
                    end
                end
            end
            isw_pkg::ST_FINISH: begin
                if (!out_valid_reg || out_ready) begin
                    out_valid_next       = 1'b1;
                    out_next.coeff_valid = valid_reg;
                    out_next.std_dev_q8  = (std_reg > isw_pkg::ROOT_W'({isw_pkg::STD_W{1'b1}}))
                                         ? {isw_pkg::STD_W{1'b1}}
                                         : std_reg[isw_pkg::STD_W-1:0];
                    out_next.is_static   = valid_reg &&
                                           (std_reg <= isw_pkg::ROOT_W'(threshold));
                    out_next.window_count = n_reg;
                    out_next.mean_x_q8   = mean_reg[0];
                    out_next.mean_y_q8   = mean_reg[1];
                    out_next.mean_z_q8   = mean_reg[2];
                    state_next           = isw_pkg::ST_IDLE;
                end
            end
            default: begin
                state_next = isw_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= isw_pkg::ST_IDLE;
            head_reg      <= '0;
            fill_reg      <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            head_reg      <= head_next;
            fill_reg      <= fill_next;
            out_valid_reg <= out_valid_next;
        end
        item_reg  <= item_next;
        k_reg     <= k_next;
        n_reg     <= n_next;
        s1_reg    <= s1_next;
        s2_reg    <= s2_next;
        d_reg     <= d_next;
        p1_reg    <= p1_next;
        p2_reg    <= p2_next;
        m_reg     <= m_next;
        axis_reg  <= axis_next;
        limit_reg <= limit_next;
        span_reg  <= span_next;
        valid_reg <= valid_next;
        std_reg   <= std_next;
        mean_reg  <= mean_next;
        out_reg   <= out_next;
    end

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            stamp_mem[wr_addr] <= item_reg.stamp;
            accel_mem[wr_addr] <= {item_reg.accel_z, item_reg.accel_y, item_reg.accel_x};
        end
        if (rd_en) begin
            stamp_q <= stamp_mem[rd_addr];
            accel_q <= accel_mem[rd_addr];
        end
    end

endmodule

/* hw/rtl/imu_static_window_detector.sv */
// ----------------------------------------------------------------------------
// imu_static_window_detector: accelerometer static window detector
// Keeps a ring of timestamped samples and reports window statistics per word.
// ----------------------------------------------------------------------------
// A sample takes longer the more entries it evicts and the fuller the ring is,
// and longer when the window is valid, since only then do the variance division
// and the root run; a clear goes straight to the result. The sample ring walk
// (a read state and an accumulate state per entry) and the bit-serial divider
// and root set this time; one item is processed at a time, two more may queue.
// Reset is synchronous and active low: it empties the ring and the queue and
// restores both registers; ring contents themselves are not cleared.
module imu_static_window_detector (
    input  logic         aclk,
    input  logic         aresetn,
    // Input word. tdata from bit 0: stamp_ns[47:0], accel_x, accel_y, accel_z.
    input  logic         s_tvalid,
    output logic         s_tready,
    input  logic [95:0]  s_tdata,
    // tuser: opcode (0 sample, 1 clear).
    input  logic [0:0]   s_tuser,
    // Result word. tdata from bit 0: std_dev_q8[23:0], is_static, window_count[8:0],
    // mean_x_q8[23:0], mean_y_q8[23:0], mean_z_q8[23:0], six zero pad bits.
    output logic         m_tvalid,
    input  logic         m_tready,
    output logic [111:0] m_tdata,
    // tuser: coeff_valid.
    output logic [0:0]   m_tuser,
    // Register port: window_ns at 0x0, excite_threshold_q8 at 0x8.
    input  logic         psel,
    input  logic         penable,
    input  logic         pwrite,
    input  logic [3:0]   paddr,
    input  logic [63:0]  pwdata,
    output logic [63:0]  prdata,
    output logic         pready
);

    logic [isw_pkg::WIN_W-1:0] window_reg;
    logic [isw_pkg::THR_W-1:0] thresh_reg;
    logic                      cfg_wr;
    logic                      item_valid, item_take;
    isw_pkg::item_t            item;
    isw_pkg::result_t          res;

    // Only address bit 3 selects a register; the rest of the offset is ignored.
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready;
    assign prdata = paddr[3] ? {40'b0, thresh_reg} : {30'b0, window_reg};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            window_reg <= isw_pkg::WIN_W'(1000000000);
            thresh_reg <= isw_pkg::THR_W'(5120);
        end else if (cfg_wr) begin
            if (paddr[3]) begin
                thresh_reg <= pwdata[isw_pkg::THR_W-1:0];
            end else begin
                window_reg <= pwdata[isw_pkg::WIN_W-1:0];
            end
        end
    end

    // The front queue keeps accepting while the back end works on a sample, until it holds two items.
    isw_front u_front (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .s_tuser    (s_tuser),
        .item_valid (item_valid),
        .item       (item),
        .item_take  (item_take)
    );

    isw_back u_back (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .item_valid (item_valid),
        .item       (item),
        .item_take  (item_take),
        .window_ns  (window_reg),
        .threshold  (thresh_reg),
        .out_valid  (m_tvalid),
        .out_result (res),
        .out_ready  (m_tready)
    );

    assign m_tuser = res.coeff_valid;
    assign m_tdata = {6'b0, res.mean_z_q8, res.mean_y_q8, res.mean_x_q8,
                      res.window_count, res.is_static, res.std_dev_q8};

endmodule

/* hw/rtl/isw_checker.sv */
// ----------------------------------------------------------------------------
// isw_checker: port-level checks of the static window detector
// Watches the result channel and reset behavior at the top-level ports.
// ----------------------------------------------------------------------------
module isw_checker (
    input logic         aclk,
    input logic         aresetn,
    input logic         m_tvalid,
    input logic         m_tready,
    input logic [111:0] m_tdata,
    input logic [0:0]   m_tuser
);

    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("result word changed while stalled");

    a_invalid_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tuser[0] |-> m_tdata[24:0] == 25'd0)
        else $error("invalid result carries a deviation or static flag");

    a_static_valid: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tdata[24] |-> m_tuser[0] && m_tdata[33:25] >= 9'd2)
        else $error("static flag without a valid window");

    a_reset: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("result valid right after reset");

endmodule

bind imu_static_window_detector isw_checker u_isw_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
);
